// ----- rtl/hhs_pkg.sv -----
package hhs_pkg;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_SLOTS   = 5;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [30:0] THR_MAX = 31'h7FFF_FFFF;

    localparam int OUT_IDX_W = 10;   // bucket_index width on the result
    localparam int IDX_EXT_W = 17;   // holds any bucket index in range
    localparam int DIV_N     = 64;   // dividend width
    localparam int DIV_D_W   = 34;   // divisor / remainder width

    // result kinds
    localparam logic [2:0] K_HOT_HIT    = 3'd0;
    localparam logic [2:0] K_HOT_CLAIM  = 3'd1;
    localparam logic [2:0] K_COLD_HIT   = 3'd2;
    localparam logic [2:0] K_COLD_CLAIM = 3'd3;
    localparam logic [2:0] K_KICK       = 3'd4;
    localparam logic [2:0] K_DECAY      = 3'd5;

    // short fingerprint is always fp[31:24], so only the full one is stored
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] fp;
        logic [39:0] kh;
        logic [63:0] kl;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic                 start;
        logic [DIV_N-1:0]     dividend;
        logic [DIV_D_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_N-1:0]     quot;
        logic [DIV_D_W-1:0]   rem;
    } t_div_rsp;

    function automatic logic [31:0] f_bump(input logic [31:0] c);
        f_bump = (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

// ----- rtl/hhs_divider.sv -----
module hhs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hhs_pkg::t_div_req i_req,
    output hhs_pkg::t_div_rsp o_rsp
);
    import hhs_pkg::*;

    localparam int CW = $clog2(DIV_N + 1);

    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_N-1:0]   r_q;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_d;

    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_q[DIV_N-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_N-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/hhs_store.sv -----
module hhs_store #(
    parameter int ROW_W = 840,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ROW_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [ROW_W-1:0] o_rdata
);
    // one row holds every slot of one bucket; rows addressed {array, bucket}
    logic [ROW_W-1:0] r_mem [2**AW];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/heavy_hitter_sketch_update_unit.sv -----
// Heavy-hitter sketch update unit (two bucket arrays, bubble ordering).
// Input beat on s_axis: one flow (hash, key). Output beat on m_axis: one
// result per flow, result kind on tuser. heavy_k is written through
// i_cfg_we / i_cfg_wdata at any time the unit is idle.
// One item at a time: s_axis_tready is high only while the unit is idle.
// Bucket indices are the low bits of the hash (array 0) and of hash plus
// short fingerprint (array 1) (BUCKETS is a power of two). A plain flow
// runs index, two row reads, decision, write back and output before the
// next accept. A cold hit adds a bubble step per swap plus bubble exit and
// kickout check; a kickout adds the target read and compare, and a write
// when the entry moves. A new peak on a hot hit with heavy_k nonzero adds
// the threshold division on the bit-serial divider. After reset the store
// is cleared one row per cycle, all 2*2^clog2(BUCKETS) rows (2048 by
// default), with s_axis_tready low; config is taken.
// The result sits in an output register; the next flow is accepted while
// it waits, and a finished result waits for the previous to drain when
// m_axis_tready is low.
module heavy_hitter_sketch_update_unit #(
    parameter int BUCKETS = hhs_pkg::DEF_BUCKETS,
    parameter int SLOTS   = hhs_pkg::DEF_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // flow_hash[63:0], flow_key_high[103:64], flow_key_low[167:104]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // array_sel[0], bucket_index[10:1], slot_pos[13:11], count_after[45:14],
    // threshold_now[76:46], eviction_seen[77], zero[79:78]
    output logic [79:0]  m_axis_tdata,
    // result_kind[2:0]
    output logic [2:0]   m_axis_tuser
);
    import hhs_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int AW    = BW + 1;
    localparam int PW    = $clog2(SLOTS);
    localparam int ROW_W = SLOTS * SLOT_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_IDX0 = 4'd2;
    localparam logic [3:0] S_IDX1 = 4'd3;
    localparam logic [3:0] S_RD0  = 4'd4;
    localparam logic [3:0] S_RD1  = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_BUB  = 4'd7;
    localparam logic [3:0] S_KCHK = 4'd8;
    localparam logic [3:0] S_KDIV = 4'd9;
    localparam logic [3:0] S_KRD  = 4'd10;
    localparam logic [3:0] S_KWR  = 4'd11;
    localparam logic [3:0] S_WR   = 4'd12;
    localparam logic [3:0] S_THR  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    typedef t_slot [SLOTS-1:0] t_row;

    // control
    logic [3:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_peak;
    logic [30:0]   r_thr;
    logic [31:0]   r_k;
    logic          r_m_valid;
    logic          r_thr_pend;

    // datapath
    logic [63:0]   r_hash;
    logic [39:0]   r_kh;
    logic [63:0]   r_kl;
    logic [63:0]   r_hv1;
    logic [BW-1:0] r_idx0;
    logic [BW-1:0] r_idx1;
    logic [BW-1:0] r_tidx;
    t_row          r_row [2];
    logic [2:0]    r_kind;
    logic          r_arr;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_bp;
    logic [31:0]   r_cnt;
    logic          r_evs;
    logic [79:0]   r_m_data;
    logic [2:0]    r_m_user;

    t_div_req      w_dreq;
    t_div_rsp      w_drsp;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [ROW_W-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [ROW_W-1:0] w_rdata;
    t_row          w_dst;

    logic [31:0]   w_fp;
    logic [7:0]    w_sfp;
    logic          w_accept;

    logic          d_found;
    logic [2:0]    d_kind;
    logic          d_arr;
    logic [PW-1:0] d_pos;
    logic [31:0]   w_bumped;
    t_slot         w_claim;

    logic [31:0]   w_l0;
    logic [31:0]   w_l1;
    logic          w_dec_arr;
    logic [31:0]   w_dec_cnt;
    logic          w_evs;

    logic          w_bub_go;
    logic          w_kick;
    logic [63:0]   w_ktgt;
    logic          w_move;
    logic [30:0]   w_cand_q;
    logic [30:0]   w_cand_c;
    logic [IDX_EXT_W-1:0] w_idx_ext;
    logic          w_out_free;

    assign w_fp     = r_hash[63:32];
    assign w_sfp    = r_hash[63:56];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_claim = t_slot'{count: 32'd1, fp: w_fp, kh: r_kh, kl: r_kl};

    // priority search: hot slots, then cold positions, array 0 before 1
    always_comb begin
        d_found = 1'b0;
        d_kind  = K_DECAY;
        d_arr   = 1'b0;
        d_pos   = '0;
        for (int a = 0; a < 2; a++) begin
            if (!d_found) begin
                if (r_row[a][0].fp == w_fp) begin
                    d_found = 1'b1;
                    d_kind  = K_HOT_HIT;
                    d_arr   = 1'(a);
                end else if (r_row[a][0].count == 32'd0) begin
                    d_found = 1'b1;
                    d_kind  = K_HOT_CLAIM;
                    d_arr   = 1'(a);
                end
            end
        end
        for (int i = 1; i < SLOTS; i++) begin
            for (int a = 0; a < 2; a++) begin
                if (!d_found) begin
                    if (r_row[a][i].fp[31:24] == w_sfp) begin
                        d_found = 1'b1;
                        d_kind  = K_COLD_HIT;
                        d_arr   = 1'(a);
                        d_pos   = PW'(i);
                    end else if (r_row[a][i].count == 32'd0) begin
                        d_found = 1'b1;
                        d_kind  = K_COLD_CLAIM;
                        d_arr   = 1'(a);
                        d_pos   = PW'(i);
                    end
                end
            end
        end
    end

    assign w_bumped = f_bump(r_row[d_arr][d_pos].count);

    // decay of the smaller last slot
    always_comb begin
        w_l0      = r_row[0][SLOTS-1].count;
        w_l1      = r_row[1][SLOTS-1].count;
        w_dec_arr = !(w_l0 < w_l1);
        w_dec_cnt = w_dec_arr ? w_l1 : w_l0;
        if (w_dec_cnt != 32'd0) begin
            w_dec_cnt = w_dec_cnt - 32'd1;
        end
        if (w_dec_arr) begin
            w_evs = (w_l0 == 32'd0) || (w_dec_cnt == 32'd0);
        end else begin
            w_evs = (w_dec_cnt == 32'd0) || (w_l1 == 32'd0);
        end
    end

    assign w_bub_go = (r_bp != '0) &&
        (r_row[r_arr][r_bp].count > r_row[r_arr][PW'(r_bp - 1'b1)].count);
    assign w_kick   = r_row[r_arr][1].count > {1'b0, r_thr};
    assign w_ktgt   = r_arr ? (r_hv1 - 64'(r_row[r_arr][1].fp[31:24]))
                            : (r_hash + 64'(r_row[r_arr][1].fp[31:24]));
    assign w_dst    = w_rdata;
    assign w_move   = r_row[r_arr][1].count > w_dst[0].count;

    assign w_cand_q = (w_drsp.quot > 64'(THR_MAX)) ? THR_MAX : w_drsp.quot[30:0];
    assign w_cand_c = (w_bumped > 32'(THR_MAX)) ? THR_MAX : w_bumped[30:0];

    // divider only serves the threshold: peak*3 / (2*heavy_k)
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = 64'({2'b00, r_peak} + {1'b0, r_peak, 1'b0});
        w_dreq.divisor  = {1'b0, r_k, 1'b0};
        case (r_state)
            S_WR: w_dreq.start = r_thr_pend;
            default: ;
        endcase
    end

    // store ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = {1'b0, r_idx0};
        case (r_state)
            S_CLR: w_we = 1'b1;
            S_IDX1: w_re = 1'b1;
            S_RD0: begin
                w_re    = 1'b1;
                w_raddr = {1'b1, r_idx1};
            end
            // kickout target read
            S_KDIV: begin
                w_re    = 1'b1;
                w_raddr = {!r_arr, w_ktgt[BW-1:0]};
            end
            S_KWR: begin
                w_we    = 1'b1;
                w_waddr = {!r_arr, r_tidx};
                w_wdata = r_row[!r_arr];
            end
            S_WR: begin
                w_we    = 1'b1;
                w_waddr = {r_arr, r_arr ? r_idx1 : r_idx0};
                w_wdata = r_row[r_arr];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_peak     <= '0;
            r_thr      <= '0;
            r_k        <= '0;
            r_m_valid  <= 1'b0;
            r_thr_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (w_accept) r_state <= S_IDX0;
                S_IDX0: r_state <= S_IDX1;
                S_IDX1: r_state <= S_RD0;
                S_RD0:  r_state <= S_RD1;
                S_RD1:  r_state <= S_DEC;
                S_DEC: begin
                    if (d_found && d_kind == K_HOT_HIT && w_bumped > r_peak) begin
                        r_peak <= w_bumped;
                        if (r_k == 32'd0) begin
                            if (w_cand_c > r_thr) r_thr <= w_cand_c;
                        end else begin
                            r_thr_pend <= 1'b1;
                        end
                    end
                    r_state <= (d_found && d_kind == K_COLD_HIT) ? S_BUB : S_WR;
                end
                S_BUB:  if (!w_bub_go) r_state <= S_KCHK;
                S_KCHK: r_state <= w_kick ? S_KDIV : S_WR;
                S_KDIV: r_state <= S_KRD;
                S_KRD:  r_state <= w_move ? S_KWR : S_WR;
                S_KWR:  r_state <= S_WR;
                S_WR: begin
                    r_thr_pend <= 1'b0;
                    r_state    <= r_thr_pend ? S_THR : S_OUT;
                end
                S_THR: begin
                    if (w_drsp.done) begin
                        if (w_cand_q > r_thr) r_thr <= w_cand_q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_idx_ext = IDX_EXT_W'(r_arr ? r_idx1 : r_idx0);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_hash <= s_axis_tdata[63:0];
                    r_kh   <= s_axis_tdata[103:64];
                    r_kl   <= s_axis_tdata[167:104];
                end
            end
            S_IDX0: begin
                r_hv1  <= r_hash + 64'(w_sfp);
                r_idx0 <= r_hash[BW-1:0];
            end
            S_IDX1: r_idx1 <= r_hv1[BW-1:0];
            S_RD0:  r_row[0] <= w_rdata;
            S_RD1:  r_row[1] <= w_rdata;
            S_DEC: begin
                r_kind <= d_kind;
                r_evs  <= 1'b0;
                if (d_found) begin
                    r_arr <= d_arr;
                    r_pos <= d_pos;
                    r_bp  <= d_pos;
                    if (d_kind == K_HOT_CLAIM || d_kind == K_COLD_CLAIM) begin
                        r_row[d_arr][d_pos] <= w_claim;
                        r_cnt <= 32'd1;
                    end else begin
                        r_row[d_arr][d_pos].count <= w_bumped;
                        r_cnt <= w_bumped;
                    end
                end else begin
                    r_arr <= w_dec_arr;
                    r_pos <= PW'(SLOTS - 1);
                    r_row[w_dec_arr][SLOTS-1].count <= w_dec_cnt;
                    r_cnt <= w_dec_cnt;
                    r_evs <= w_evs;
                end
            end
            S_BUB: begin
                if (w_bub_go) begin
                    r_row[r_arr][r_bp] <= r_row[r_arr][PW'(r_bp - 1'b1)];
                    r_row[r_arr][PW'(r_bp - 1'b1)] <= r_row[r_arr][r_bp];
                    r_bp <= r_bp - 1'b1;
                end
            end
            S_KDIV: r_tidx <= w_ktgt[BW-1:0];
            S_KRD: begin
                if (w_move) begin
                    r_kind <= K_KICK;
                    // target shifts down, moved entry lands in its hot slot
                    r_row[!r_arr][0] <= r_row[r_arr][1];
                    for (int i = 1; i < SLOTS; i++) begin
                        r_row[!r_arr][i] <= w_dst[i-1];
                    end
                    // source closes the gap behind slot 1
                    for (int i = 1; i < SLOTS - 1; i++) begin
                        r_row[r_arr][i] <= r_row[r_arr][i+1];
                    end
                    r_row[r_arr][SLOTS-1] <= '0;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_m_user <= r_kind;
                    r_m_data <= {2'b00, r_evs, r_thr, r_cnt, 3'(r_pos),
                                 w_idx_ext[OUT_IDX_W-1:0], r_arr};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    hhs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    hhs_store #(
        .ROW_W (ROW_W),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

// ----- rtl/hhs_checker.sv -----
module hhs_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import hhs_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // one flow at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    a_evict_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_DECAY |-> !m_axis_tdata[77])
        else $error("eviction flag outside a decay");

    a_hot_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_HOT_HIT || m_axis_tuser == K_HOT_CLAIM)
            |-> m_axis_tdata[13:11] == 3'd0)
        else $error("hot result not at slot zero");

    a_claim_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_HOT_CLAIM || m_axis_tuser == K_COLD_CLAIM)
            |-> m_axis_tdata[45:14] == 32'd1)
        else $error("claim count not one");

endmodule

bind heavy_hitter_sketch_update_unit hhs_props u_hhs_checker (.*);
